// File: design/trsch_pkg.sv
// Shared types and constants for the thread slot round-robin scheduler.
package trsch_pkg;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int SLOT_ID_W     = 4;

    typedef enum logic [1:0] {
        SLOT_EMPTY    = 2'd0,
        SLOT_RUNNABLE = 2'd1,
        SLOT_FINISHED = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        EV_TICK   = 2'd0,
        EV_CREATE = 2'd1,
        EV_FINISH = 2'd2,
        EV_JOIN   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        JOIN_ALREADY = 2'd0,
        JOIN_DONE    = 2'd1,
        JOIN_WAIT    = 2'd2
    } join_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_ACCESS,
        FSM_CHECK,
        FSM_DONE
    } fsm_state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_ID_W-1:0]  target_slot;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_ID_W-1:0]  running_slot;
        logic                  switched;
        logic [SLOT_ID_W-1:0]  new_slot;
        logic                  create_ok;
        join_t                 join_result;
    } out_item_t;

endpackage

// File: design/trsch_ram.sv
// Generic single-write, single-read RAM with registered read data.
module trsch_ram #(
    parameter int WIDTH  = 2,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/trsch_table.sv
// Slot state table: RAM plus per-slot valid bits that stand in for the reset contents.
module trsch_table #(
    parameter int NUM_SLOTS = trsch_pkg::DEF_NUM_SLOTS,
    parameter int SLOT_W    = $clog2(NUM_SLOTS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [SLOT_W-1:0]      rd_addr,
    input  logic                   wr_en,
    input  logic [SLOT_W-1:0]      wr_addr,
    input  trsch_pkg::slot_state_t wr_state,
    output trsch_pkg::slot_state_t rd_state
);

    import trsch_pkg::*;

    logic [NUM_SLOTS-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic                 rd_zero_reg;
    logic [1:0]           ram_data;

    trsch_ram #(
        .WIDTH (2),
        .DEPTH (NUM_SLOTS),
        .ADDR_W(SLOT_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_state),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(ram_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_zero_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_zero_reg  <= (rd_addr == '0);
            end
        end
    end

    // A slot never written holds its reset state: the main thread is runnable.
    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_state = slot_state_t'(ram_data);
        end
        else if (rd_zero_reg)
        begin
            rd_state = SLOT_RUNNABLE;
        end
        else
        begin
            rd_state = SLOT_EMPTY;
        end
    end

endmodule

// File: design/trsch_ctrl.sv
// Event sequencer: scans the slot table one entry per cycle and builds the result.
module trsch_ctrl #(
    parameter int NUM_SLOTS = trsch_pkg::DEF_NUM_SLOTS,
    parameter int SLOT_W    = $clog2(NUM_SLOTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  trsch_pkg::in_item_t  item,
    output logic                 idle,
    input  logic                 res_free,
    output logic                 res_load,
    output trsch_pkg::out_item_t result
);

    import trsch_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    fsm_state_t            state_reg, state_next;
    kind_t                 kind_reg, kind_next;
    logic [SLOT_ID_W-1:0]  tgt_reg, tgt_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                  switched_reg, switched_next;
    logic [SLOT_W-1:0]     new_slot_reg, new_slot_next;
    logic                  create_ok_reg, create_ok_next;
    join_t                 join_reg, join_next;

    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    slot_state_t           wr_state;
    slot_state_t           rd_state;
    logic                  match;
    logic                  in_range;

    trsch_table #(
        .NUM_SLOTS(NUM_SLOTS),
        .SLOT_W   (SLOT_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_state(wr_state),
        .rd_state(rd_state)
    );

    function automatic logic [SLOT_W-1:0] next_idx(input logic [SLOT_W-1:0] i);
        next_idx = (i == LAST_SLOT) ? '0 : i + SLOT_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cur_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            kind_reg      <= EV_TICK;
            tgt_reg       <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            chk_idx_reg   <= '0;
            switched_reg  <= 1'b0;
            new_slot_reg  <= '0;
            create_ok_reg <= 1'b0;
            join_reg      <= JOIN_ALREADY;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            chk_vld_reg   <= chk_vld_next;
            kind_reg      <= kind_next;
            tgt_reg       <= tgt_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            chk_idx_reg   <= chk_idx_next;
            switched_reg  <= switched_next;
            new_slot_reg  <= new_slot_next;
            create_ok_reg <= create_ok_next;
            join_reg      <= join_next;
        end
    end

    assign in_range = (32'(tgt_reg) < NUM_SLOTS);
    assign match    = (kind_reg == EV_TICK) ? (rd_state == SLOT_RUNNABLE)
                                            : (rd_state == SLOT_EMPTY);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        tgt_next       = tgt_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        switched_next  = switched_reg;
        new_slot_next  = new_slot_reg;
        create_ok_next = create_ok_reg;
        join_next      = join_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_state       = SLOT_RUNNABLE;
        res_load       = 1'b0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    kind_next      = item.kind;
                    tgt_next       = item.target_slot;
                    switched_next  = 1'b0;
                    new_slot_next  = '0;
                    create_ok_next = 1'b0;
                    join_next      = JOIN_ALREADY;
                    cnt_next       = '0;
                    chk_vld_next   = 1'b0;
                    // Tick scans from the slot after the running one, create from slot 1.
                    idx_next = (item.kind == EV_TICK) ? next_idx(cur_reg) : SLOT_W'(1);
                    if (item.kind == EV_TICK || item.kind == EV_CREATE)
                    begin
                        state_next = FSM_SCAN;
                    end
                    else
                    begin
                        state_next = FSM_ACCESS;
                    end
                end
            end

            FSM_SCAN:
            begin
                // Reads stream one per cycle; each slot is checked in the cycle after its read.
                rd_en        = (cnt_reg != LAST_SLOT);
                idx_next     = next_idx(idx_reg);
                cnt_next     = rd_en ? cnt_reg + SLOT_W'(1) : cnt_reg;
                chk_vld_next = rd_en;
                chk_idx_next = idx_reg;
                if (chk_vld_reg && match)
                begin
                    if (kind_reg == EV_TICK)
                    begin
                        cur_next      = chk_idx_reg;
                        switched_next = 1'b1;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_state       = SLOT_RUNNABLE;
                        new_slot_next  = chk_idx_reg;
                        create_ok_next = 1'b1;
                    end
                    state_next = FSM_DONE;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    state_next = FSM_DONE;
                end
            end

            FSM_ACCESS:
            begin
                rd_en      = 1'b1;
                rd_addr    = SLOT_W'(tgt_reg);
                state_next = FSM_CHECK;
            end

            FSM_CHECK:
            begin
                wr_addr = SLOT_W'(tgt_reg);
                if (kind_reg == EV_FINISH)
                begin
                    if (tgt_reg != '0 && in_range && rd_state == SLOT_RUNNABLE)
                    begin
                        wr_en    = 1'b1;
                        wr_state = SLOT_FINISHED;
                    end
                end
                else
                begin
                    if (!in_range || rd_state == SLOT_EMPTY)
                    begin
                        join_next = JOIN_ALREADY;
                    end
                    else if (rd_state == SLOT_FINISHED)
                    begin
                        wr_en     = 1'b1;
                        wr_state  = SLOT_EMPTY;
                        join_next = JOIN_DONE;
                    end
                    else
                    begin
                        join_next = JOIN_WAIT;
                    end
                end
                state_next = FSM_DONE;
            end

            FSM_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == FSM_IDLE);

    assign result.running_slot = SLOT_ID_W'(cur_reg);
    assign result.switched     = switched_reg;
    assign result.new_slot     = SLOT_ID_W'(new_slot_reg);
    assign result.create_ok    = create_ok_reg;
    assign result.join_result  = join_reg;

endmodule

// File: design/thread_slot_round_robin_scheduler.sv
// Top level of the round-robin thread slot scheduler with its result register.
//
//   Channel   Signals                    Payload      Direction
//   event     evt_valid / evt_stall      in_item_t    into the block
//   result    res_valid / res_stall      out_item_t   out of the block
//
// A tick or create scans the slot table one slot per cycle, as the table has one read
// port, and stops early at the first matching slot.
// A finish or join reads its target slot once, then checks it and updates it if needed.
// Reset puts slot 0 as runnable and running and all other slots empty.
// Events are taken whenever the sequencer is idle, even while a result waits;
// a stalled result holds the sequencer in its final state until the register frees.
module thread_slot_round_robin_scheduler #(
    parameter int NUM_SLOTS = trsch_pkg::DEF_NUM_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 evt_valid,
    output logic                 evt_stall,
    input  trsch_pkg::in_item_t  evt,
    output logic                 res_valid,
    input  logic                 res_stall,
    output trsch_pkg::out_item_t res
);

    import trsch_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic      idle;
    logic      start;
    logic      res_free;
    logic      res_load;
    out_item_t result;
    logic      res_valid_reg;
    out_item_t res_reg;

    assign evt_stall = !idle;
    assign start     = evt_valid && idle;
    assign res_free  = !res_valid_reg || !res_stall;

    trsch_ctrl #(
        .NUM_SLOTS(NUM_SLOTS),
        .SLOT_W   (SLOT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (evt),
        .idle    (idle),
        .res_free(res_free),
        .res_load(res_load),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
